FILE: rtl/psmm_pkg.sv
`default_nettype none

package psmm_pkg;

	// Memory geometry. PAGE_BYTES is expected to be a power of two.
	localparam int PAGE_BYTES = 16384;
	localparam int SLOT_COUNT = 4;
	localparam int PAGES      = 4;
	localparam int PAGE_W     = $clog2(PAGE_BYTES);
	localparam int SLOT_W     = (SLOT_COUNT > 2) ? 2 : 1;
	localparam int SLOT_BYTES = PAGES * PAGE_BYTES;
	localparam int MEM_DEPTH  = SLOT_COUNT * SLOT_BYTES;
	localparam int MEM_AW     = $clog2(MEM_DEPTH);

	// The RAM slots (slot 2 and up) are zeroed after reset.
	localparam int CLEAR_BASE   = 2 * SLOT_BYTES;
	localparam bit CLEAR_NEEDED = (CLEAR_BASE < MEM_DEPTH);

	localparam logic [7:0]  READ_UNMAPPED   = 8'hff;
	localparam logic [15:0] ROM_MASK_RESET  = 16'h0003;
	localparam logic [15:0] EN_MASK_RESET   = 16'hf003;
	localparam logic [3:0]  PAGE_FLAG_RESET = 4'b0011;

	typedef enum logic [1:0] {
		KIND_READ    = 2'd0,
		KIND_WRITE   = 2'd1,
		KIND_SELECT  = 2'd2,
		KIND_PRELOAD = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_ROM_MASK = 2'd0,
		CFG_EN_MASK  = 2'd1,
		CFG_SPARE2   = 2'd2,
		CFG_SPARE3   = 2'd3
	} cfg_index_t;

	// Latched mapping of one page.
	typedef struct packed {
		logic [1:0] slot;
		logic       read_only;
		logic       enabled;
	} page_info_t;

	function automatic logic slot_exists(input logic [1:0] slot);
		return ({1'b0, slot} < 3'(SLOT_COUNT));
	endfunction

	// Byte address inside the slot memory. The page offset uses address bits
	// 13..0 only, so a small page mirrors and a large page is only partly reachable.
	function automatic logic [MEM_AW-1:0] mem_addr(input logic [1:0] slot,
			input logic [15:0] address);
		return {SLOT_W'(slot), address[15:14], PAGE_W'(address[13:0])};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/psmm_ram.sv
`default_nettype none

module psmm_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en && !we) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/psmm_page_map.sv
`default_nettype none

module psmm_page_map (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [15:0]            cfg_data,
	input  wire logic                   sel_we,
	input  wire logic [7:0]             sel_data,
	input  wire logic [1:0]             lookup_page,
	output psmm_pkg::page_info_t        info
);

	logic [15:0] rom_mask_q;
	logic [15:0] en_mask_q;
	logic [1:0]  slot_q [psmm_pkg::PAGES];
	logic [3:0]  ro_q;
	logic [3:0]  en_q;
	logic [3:0]  ro_next;
	logic [3:0]  en_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_mask_q <= psmm_pkg::ROM_MASK_RESET;
			en_mask_q  <= psmm_pkg::EN_MASK_RESET;
		end else if (cfg_we) begin
			case (psmm_pkg::cfg_index_t'(cfg_index))
				psmm_pkg::CFG_ROM_MASK: rom_mask_q <= cfg_data;
				psmm_pkg::CFG_EN_MASK:  en_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flags of each page come from the mask bit slot*4+page of the new slot.
	always_comb begin
		logic [1:0] sl;
		logic [3:0] bitn;
		ro_next = '0;
		en_next = '0;
		for (int p = 0; p < psmm_pkg::PAGES; p++) begin
			sl   = sel_data[2*p +: 2];
			bitn = {sl, 2'(p)};
			if (psmm_pkg::slot_exists(sl)) begin
				ro_next[p] = rom_mask_q[bitn];
				en_next[p] = en_mask_q[bitn];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < psmm_pkg::PAGES; p++) begin
				slot_q[p] <= 2'd0;
			end
			ro_q <= psmm_pkg::PAGE_FLAG_RESET;
			en_q <= psmm_pkg::PAGE_FLAG_RESET;
		end else if (sel_we) begin
			for (int p = 0; p < psmm_pkg::PAGES; p++) begin
				slot_q[p] <= sel_data[2*p +: 2];
			end
			ro_q <= ro_next;
			en_q <= en_next;
		end
	end

	assign info.slot      = slot_q[lookup_page];
	assign info.read_only = ro_q[lookup_page];
	assign info.enabled   = en_q[lookup_page];

endmodule

`default_nettype wire

FILE: rtl/paged_slot_memory_mapper.sv
// Paged slot memory mapper. The 64 KiB CPU space is cut into four 16 KiB
// pages, and each page is routed to one of four slots by a slot-select
// transaction, which also latches that slot's read-only and populated flags
// from the two mask registers (a mask change takes effect at the next slot
// select). Every input transaction yields exactly one output transaction:
// read_data carries the byte of a memory read (0xFF from an unpopulated
// page, 0 for all other kinds) and write_dropped flags a memory write that
// hit a read-only or unpopulated page. Preload transactions write any slot
// directly and ignore the flags. The block takes one transaction per clock
// while neither the clearing pass nor back-pressure from out_stall holds it;
// an accepted transaction passes through the input register, the
// single-port slot RAM access and then the output register.
// The RAM port is shared by reads, writes and preloads, so they stay in order
// with no forwarding. After reset the RAM slots 2 and 3 are zeroed by a
// clearing pass that writes one byte per cycle; in_stall stays high during
// the pass while configuration writes are still taken. Bytes of slots
// 0 and 1 read before any write are undefined.

`default_nettype none

module paged_slot_memory_mapper (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  data,
	input  wire logic [1:0]  preload_slot,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_data,
	output logic             write_dropped,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam logic [psmm_pkg::MEM_AW-1:0] CLEAR_LAST =
		psmm_pkg::MEM_AW'(psmm_pkg::MEM_DEPTH - 1);

	// Clearing pass over the RAM slots.
	logic                        clearing_q;
	logic [psmm_pkg::MEM_AW-1:0] clear_ptr_q;

	// Stage 1: registered input transaction.
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;
	logic [1:0]  preload_slot_s1;

	// Stage 2: RAM access done, read data sits in the RAM output register.
	logic        valid_s2;
	logic        use_ram_s2;
	logic [7:0]  const_s2;
	logic        dropped_s2;

	// Output register.
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic        dropped_q;

	logic in_acc;
	logic out_adv;
	logic s2_free;
	logic s2_move;
	logic s1_move;

	psmm_pkg::page_info_t info;

	logic                        do_read;
	logic                        do_write;
	logic                        do_select;
	logic                        use_ram;
	logic [7:0]                  const_val;
	logic                        dropped;
	logic [psmm_pkg::MEM_AW-1:0] item_addr;

	logic                        ram_en;
	logic                        ram_we;
	logic [psmm_pkg::MEM_AW-1:0] ram_addr;
	logic [7:0]                  ram_wdata;
	logic [7:0]                  ram_rdata;

	// Each stage moves on when the stage after it is empty or moving, so
	// bubbles fill while a result waits at the output.
	assign out_adv  = !out_valid_q || !out_stall;
	assign s2_move  = valid_s2 && out_adv;
	assign s2_free  = !valid_s2 || out_adv;
	assign s1_move  = valid_s1 && s2_free;
	assign in_stall = clearing_q || (valid_s1 && !s2_free);
	assign in_acc   = in_valid && !in_stall;

	// Configuration registers never stall.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= psmm_pkg::CLEAR_NEEDED;
			clear_ptr_q <= psmm_pkg::MEM_AW'(psmm_pkg::CLEAR_BASE);
		end else if (clearing_q) begin
			clear_ptr_q <= clear_ptr_q + 1'b1;
			if (clear_ptr_q == CLEAR_LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1         <= kind;
			address_s1      <= address;
			data_s1         <= data;
			preload_slot_s1 <= preload_slot;
		end
	end

	psmm_page_map u_page_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sel_we      (s1_move && do_select),
		.sel_data    (data_s1),
		.lookup_page (address_s1[15:14]),
		.info        (info)
	);

	// Decode of the stage 1 transaction against the latched page mapping.
	// An enabled page always maps to an existing slot.
	always_comb begin
		do_read   = 1'b0;
		do_write  = 1'b0;
		do_select = 1'b0;
		use_ram   = 1'b0;
		const_val = 8'h00;
		dropped   = 1'b0;
		item_addr = psmm_pkg::mem_addr(info.slot, address_s1);
		case (psmm_pkg::kind_t'(kind_s1))
			psmm_pkg::KIND_READ: begin
				if (info.enabled) begin
					do_read = 1'b1;
					use_ram = 1'b1;
				end else begin
					const_val = psmm_pkg::READ_UNMAPPED;
				end
			end
			psmm_pkg::KIND_WRITE: begin
				if (info.read_only || !info.enabled) begin
					dropped = 1'b1;
				end else begin
					do_write = 1'b1;
				end
			end
			psmm_pkg::KIND_SELECT: begin
				do_select = 1'b1;
			end
			psmm_pkg::KIND_PRELOAD: begin
				do_write  = psmm_pkg::slot_exists(preload_slot_s1);
				item_addr = psmm_pkg::mem_addr(preload_slot_s1, address_s1);
			end
			default: ;
		endcase
	end

	// The clearing pass owns the RAM port; no transaction is in flight then.
	assign ram_en    = clearing_q || (s1_move && (do_read || do_write));
	assign ram_we    = clearing_q || do_write;
	assign ram_addr  = clearing_q ? clear_ptr_q : item_addr;
	assign ram_wdata = clearing_q ? 8'h00 : data_s1;

	psmm_ram #(
		.DEPTH (psmm_pkg::MEM_DEPTH),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move) begin
			valid_s2 <= 1'b1;
		end else if (s2_move) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			use_ram_s2 <= use_ram;
			const_s2   <= const_val;
			dropped_s2 <= dropped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			read_data_q <= use_ram_s2 ? ram_rdata : const_s2;
			dropped_q   <= dropped_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign write_dropped = dropped_q;

	// No transaction may reach the RAM stage while the clearing pass runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !valid_s2)
		else $error("transaction in flight during clearing pass");

	// A held stage 2 transaction keeps its RAM read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_adv |=> valid_s2 && $stable(ram_rdata) && $stable(use_ram_s2))
		else $error("stage 2 lost its data while stalled");

	// The clearing pass ends only after the last RAM entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(clear_ptr_q) == CLEAR_LAST)
		else $error("clearing pass ended early");

	// A dropped write never carries read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && dropped_q |-> read_data_q == 8'h00)
		else $error("dropped write with nonzero read data");

endmodule

`default_nettype wire
